// ----- src/stli_pkg.sv -----
// ----------------------------------------------------------------------------
// stli_pkg: shared types and constants
// Opcodes, status codes and datapath widths for the sorted-table interpolator.
// ----------------------------------------------------------------------------
package stli_pkg;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_MISS    = 3'd1;
    localparam logic [2:0] ST_STORED  = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_CLEARED = 3'd4;

    // magnitudes of 33-bit differences
    localparam int MAG_W  = 33;
    // product of two magnitudes, divider dividend and quotient
    localparam int PROD_W = 2 * MAG_W;
    // saturated quotient, up to 2^33
    localparam int QUOT_W = MAG_W + 1;

    typedef logic [MAG_W-1:0]  mag_t;
    typedef logic [QUOT_W-1:0] quot_t;

endpackage

// ----- src/stli_muldiv.sv -----
// ----------------------------------------------------------------------------
// stli_muldiv: serial multiply-then-divide unit
// Computes a*b/d on magnitudes with one shared adder: shift-add multiply,
// then restoring division, one bit per cycle. Quotient saturates at 2^33.
// ----------------------------------------------------------------------------
module stli_muldiv
    import stli_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  mag_t  a_mag,
    input  mag_t  b_mag,
    input  mag_t  d_mag,
    output logic  done,
    output quot_t quot
);

    typedef enum logic [2:0] {
        MD_IDLE = 3'b001,
        MD_MUL  = 3'b010,
        MD_DIV  = 3'b100
    } md_state_t;

    localparam logic [6:0] MUL_STEPS = 7'(MAG_W);
    localparam logic [6:0] DIV_STEPS = 7'(PROD_W);

    md_state_t          state_reg, state_next;
    logic [6:0]         step_reg, step_next;
    logic               done_reg, done_next;
    logic [MAG_W:0]     rem_reg, rem_next;
    logic [PROD_W-1:0]  work_reg, work_next;
    mag_t               a_reg, a_next;
    mag_t               d_reg, d_next;

    logic [MAG_W:0]     add_a;
    logic [MAG_W:0]     add_b;
    logic               add_cin;
    logic [MAG_W+1:0]   add_sum;
    logic [MAG_W:0]     shifted;
    logic               ge;

    assign shifted = {rem_reg[MAG_W-1:0], work_reg[PROD_W-1]};
    assign ge      = add_sum[MAG_W+1];
    assign add_sum = {1'b0, add_a} + {1'b0, add_b} + {{(MAG_W+1){1'b0}}, add_cin};

    always_comb
    begin
        if (state_reg == MD_DIV)
        begin
            add_a   = shifted;
            add_b   = ~{1'b0, d_reg};
            add_cin = 1'b1;
        end
        else
        begin
            add_a   = rem_reg;
            add_b   = work_reg[0] ? {1'b0, a_reg} : '0;
            add_cin = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        rem_next   = rem_reg;
        work_next  = work_reg;
        a_next     = a_reg;
        d_next     = d_reg;
        unique case (state_reg)
            MD_IDLE:
            begin
                if (start)
                begin
                    a_next     = a_mag;
                    d_next     = d_mag;
                    rem_next   = '0;
                    work_next  = {{(PROD_W-MAG_W){1'b0}}, b_mag};
                    step_next  = MUL_STEPS;
                    state_next = MD_MUL;
                end
            end
            MD_MUL:
            begin
                if (step_reg == 7'd1)
                begin
                    work_next  = {add_sum[MAG_W:0], work_reg[MAG_W-1:1]};
                    rem_next   = '0;
                    step_next  = DIV_STEPS;
                    state_next = MD_DIV;
                end
                else
                begin
                    rem_next  = {1'b0, add_sum[MAG_W:1]};
                    work_next = {work_reg[PROD_W-1:MAG_W], add_sum[0],
                                 work_reg[MAG_W-1:1]};
                    step_next = step_reg - 7'd1;
                end
            end
            MD_DIV:
            begin
                rem_next  = ge ? add_sum[MAG_W:0] : shifted;
                work_next = {work_reg[PROD_W-2:0], ge};
                step_next = step_reg - 7'd1;
                if (step_reg == 7'd1)
                begin
                    done_next  = 1'b1;
                    state_next = MD_IDLE;
                end
            end
            default:
            begin
                state_next = MD_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        work_reg <= work_next;
        a_reg    <= a_next;
        d_reg    <= d_next;
    end

    // saturate at 2^33
    always_comb
    begin
        if ((|work_reg[PROD_W-1:QUOT_W]) ||
            (work_reg[QUOT_W-1] && (|work_reg[QUOT_W-2:0])))
        begin
            quot = {1'b1, {(QUOT_W-1){1'b0}}};
        end
        else
        begin
            quot = work_reg[QUOT_W-1:0];
        end
    end

    assign done = done_reg;

endmodule

// ----- src/sorted_table_linear_interpolator.sv -----
// ----------------------------------------------------------------------------
// sorted_table_linear_interpolator
// Point table with clear/append/query beats; a query binary-searches the
// table for the bracketing pair and interpolates with a serial mul/div unit.
//
//   channel  handshake             payload
//   req      req_valid/req_stall   opcode, position, sample_value
//   rsp      rsp_valid/rsp_stall   result_value, status
//
// Clear and append set the result register on accept and go to the output state.
// Query: the 33-step multiply and 66-step divide in stli_muldiv dominate;
// the search reads each probe through the table read port, in a read
// state and then a compare state.
// rst_n clears the sequencer, point count and rsp_valid; table contents
// and result values are not cleared. req_stall is high while an item is
// in work; a held result waits in the output register under rsp_stall.
// ----------------------------------------------------------------------------
module sorted_table_linear_interpolator
    import stli_pkg::*;
#(
    parameter int TABLE_DEPTH = 4096
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [1:0]         opcode,
    input  logic [31:0]        position,
    input  logic signed [31:0] sample_value,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic signed [31:0] result_value,
    output logic [2:0]         status
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic signed [34:0] VAL_MAX = 35'sd2147483647;
    localparam logic signed [34:0] VAL_MIN = -35'sd2147483648;

    typedef enum logic [11:0] {
        S_IDLE     = 12'b000000000001,
        S_RD_LO    = 12'b000000000010,
        S_RD_HI    = 12'b000000000100,
        S_CHK_HI   = 12'b000000001000,
        S_SRCH_RD  = 12'b000000010000,
        S_SRCH_CMP = 12'b000000100000,
        S_DIFF     = 12'b000001000000,
        S_MAG      = 12'b000010000000,
        S_GO       = 12'b000100000000,
        S_MD       = 12'b001000000000,
        S_SUM      = 12'b010000000000,
        S_OUT      = 12'b100000000000
    } state_t;

    state_t                state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    logic signed [31:0]    rsp_value_reg, rsp_value_next;
    logic [2:0]            rsp_status_reg, rsp_status_next;

    logic [31:0]           x_reg, x_next;
    logic [AW-1:0]         lo_reg, lo_next;
    logic [AW-1:0]         hi_reg, hi_next;
    logic [31:0]           plo_reg, plo_next;
    logic [31:0]           phi_reg, phi_next;
    logic signed [31:0]    vlo_reg, vlo_next;
    logic signed [31:0]    vhi_reg, vhi_next;
    logic [MAG_W-1:0]      dx_reg, dx_next;
    logic [MAG_W-1:0]      dv_reg, dv_next;
    logic [MAG_W-1:0]      dp_reg, dp_next;
    mag_t                  dxm_reg, dxm_next;
    mag_t                  dvm_reg, dvm_next;
    mag_t                  dpm_reg, dpm_next;
    logic                  neg_reg, neg_next;
    logic signed [31:0]    res_value_reg, res_value_next;
    logic [2:0]            res_status_reg, res_status_next;

    logic [31:0]           pos_mem [TABLE_DEPTH];
    logic [31:0]           val_mem [TABLE_DEPTH];
    logic [31:0]           pos_q;
    logic signed [31:0]    val_q;
    logic [AW-1:0]         rd_addr;
    logic                  wr_en;

    logic [AW-1:0]         span;
    logic [AW-1:0]         mid;
    logic                  accept;
    logic                  md_start;
    logic                  md_done;
    quot_t                 md_quot;
    logic signed [34:0]    sum_wide;

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign span      = hi_reg - lo_reg;
    assign mid       = lo_reg + (span >> 1);
    assign md_start  = (state_reg == S_GO);
    assign wr_en     = accept && (opcode == OP_APPEND) && (count_reg < CW'(TABLE_DEPTH));

    always_comb
    begin
        unique case (state_reg)
            S_RD_LO:   rd_addr = lo_reg;
            S_RD_HI:   rd_addr = hi_reg;
            S_SRCH_RD: rd_addr = mid;
            default:   rd_addr = lo_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pos_mem[count_reg[AW-1:0]] <= position;
            val_mem[count_reg[AW-1:0]] <= sample_value;
        end
        pos_q <= pos_mem[rd_addr];
        val_q <= val_mem[rd_addr];
    end

    stli_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (md_start),
        .a_mag (dxm_reg),
        .b_mag (dvm_reg),
        .d_mag (dpm_reg),
        .done  (md_done),
        .quot  (md_quot)
    );

    assign sum_wide = neg_reg ? (35'(vlo_reg) - $signed({1'b0, md_quot}))
                              : (35'(vlo_reg) + $signed({1'b0, md_quot}));

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_value_next  = rsp_value_reg;
        rsp_status_next = rsp_status_reg;
        x_next          = x_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        plo_next        = plo_reg;
        phi_next        = phi_reg;
        vlo_next        = vlo_reg;
        vhi_next        = vhi_reg;
        dx_next         = dx_reg;
        dv_next         = dv_reg;
        dp_next         = dp_reg;
        dxm_next        = dxm_reg;
        dvm_next        = dvm_reg;
        dpm_next        = dpm_reg;
        neg_next        = neg_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    x_next          = position;
                    res_value_next  = '0;
                    res_status_next = ST_MISS;
                    state_next      = S_OUT;
                    unique case (opcode)
                        OP_CLEAR:
                        begin
                            count_next      = '0;
                            res_status_next = ST_CLEARED;
                        end
                        OP_APPEND:
                        begin
                            if (wr_en)
                            begin
                                count_next      = count_reg + CW'(1);
                                res_status_next = ST_STORED;
                            end
                            else
                            begin
                                res_status_next = ST_FULL;
                            end
                        end
                        OP_QUERY:
                        begin
                            if (count_reg != '0)
                            begin
                                lo_next    = '0;
                                hi_next    = AW'(count_reg - CW'(1));
                                state_next = S_RD_LO;
                            end
                        end
                        default:
                        begin
                            res_status_next = ST_MISS;
                        end
                    endcase
                end
            end
            S_RD_LO:
            begin
                state_next = S_RD_HI;
            end
            S_RD_HI:
            begin
                plo_next = pos_q;
                vlo_next = val_q;
                if (x_reg < pos_q)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_CHK_HI;
                end
            end
            S_CHK_HI:
            begin
                phi_next = pos_q;
                vhi_next = val_q;
                if (x_reg > pos_q)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_SRCH_RD;
                end
            end
            S_SRCH_RD:
            begin
                if (span > AW'(1))
                begin
                    state_next = S_SRCH_CMP;
                end
                else
                begin
                    state_next = S_DIFF;
                end
            end
            S_SRCH_CMP:
            begin
                if (x_reg > pos_q)
                begin
                    lo_next  = mid;
                    plo_next = pos_q;
                    vlo_next = val_q;
                end
                else
                begin
                    hi_next  = mid;
                    phi_next = pos_q;
                    vhi_next = val_q;
                end
                state_next = S_SRCH_RD;
            end
            S_DIFF:
            begin
                dx_next    = {1'b0, x_reg} - {1'b0, plo_reg};
                dv_next    = MAG_W'(vhi_reg) - MAG_W'(vlo_reg);
                dp_next    = {1'b0, phi_reg} - {1'b0, plo_reg};
                state_next = S_MAG;
            end
            S_MAG:
            begin
                dxm_next = dx_reg[MAG_W-1] ? (~dx_reg + MAG_W'(1)) : dx_reg;
                dvm_next = dv_reg[MAG_W-1] ? (~dv_reg + MAG_W'(1)) : dv_reg;
                dpm_next = dp_reg[MAG_W-1] ? (~dp_reg + MAG_W'(1)) : dp_reg;
                neg_next = dx_reg[MAG_W-1] ^ dv_reg[MAG_W-1] ^ dp_reg[MAG_W-1];
                if ((dx_reg == '0) || (dv_reg == '0))
                begin
                    neg_next = 1'b0;
                end
                res_status_next = ST_OK;
                if (dp_reg == '0)
                begin
                    res_value_next = vlo_reg;
                    state_next     = S_OUT;
                end
                else
                begin
                    state_next = S_GO;
                end
            end
            S_GO:
            begin
                state_next = S_MD;
            end
            S_MD:
            begin
                if (md_done)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                priority if (sum_wide > VAL_MAX)
                begin
                    res_value_next = 32'sh7FFFFFFF;
                end
                else if (sum_wide < VAL_MIN)
                begin
                    res_value_next = 32'sh80000000;
                end
                else
                begin
                    res_value_next = sum_wide[31:0];
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_value_next  = res_value_reg;
                    rsp_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_value_reg  <= rsp_value_next;
        rsp_status_reg <= rsp_status_next;
        x_reg          <= x_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        plo_reg        <= plo_next;
        phi_reg        <= phi_next;
        vlo_reg        <= vlo_next;
        vhi_reg        <= vhi_next;
        dx_reg         <= dx_next;
        dv_reg         <= dv_next;
        dp_reg         <= dp_next;
        dxm_reg        <= dxm_next;
        dvm_reg        <= dvm_next;
        dpm_reg        <= dpm_next;
        neg_reg        <= neg_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
    end

    assign rsp_valid    = rsp_valid_reg;
    assign result_value = rsp_value_reg;
    assign status       = rsp_status_reg;

endmodule
